/* sv/qvr_pkg.sv */
package qvr_pkg;

	// Configuration port geometry.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_AW-1:0] REG_QUAT_X = 3'd0;
	localparam logic [CFG_AW-1:0] REG_QUAT_Y = 3'd1;
	localparam logic [CFG_AW-1:0] REG_QUAT_Z = 3'd2;
	localparam logic [CFG_AW-1:0] REG_QUAT_W = 3'd3;
	localparam logic [CFG_AW-1:0] REG_EPS    = 3'd4;

	// Reset values of the registers.
	localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;
	localparam logic [13:0]        EPS_RESET    = 14'd1;

	// Latency from an accepted beat to its result strobe.
	localparam int PIPE_LATENCY = 5;

	typedef struct packed {
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
		logic signed [15:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
	} rot_t;

endpackage

/* sv/quaternion_vector_rotate.sv */
// Quaternion vector rotation.
//
// The quaternion (quat_x, quat_y, quat_z, quat_w, signed Q2.14) and the
// normalization threshold length_epsilon are written on the cfg_we /
// cfg_addr / cfg_wdata port. Each write, and reset, starts a setup pass that
// squares and sums the components, takes the square root one bit per cycle,
// and if the length exceeds length_epsilon divides each component by it in
// a restoring divider, then precomputes s*s - u.u. Busy is high during that
// pass, which lasts longer with normalization than without it.
//
// A vector beat (vec, signed Q8.8) is taken at each clock edge where start
// is high and busy is low, one per cycle. Its rotated vector appears on rot
// with done high for one cycle, once it has passed the five stage pipeline
// (products, sums, products, accumulate, round and saturate). The receiver
// cannot stall the output.
//
// Reset clears the pipeline valid bits, loads the identity quaternion and
// runs the setup pass before the first beat can be taken.
module quaternion_vector_rotate (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  qvr_pkg::vec_t                vec,
	output logic                         done,
	output qvr_pkg::rot_t                rot,
	input  logic                         cfg_we,
	input  logic [qvr_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [qvr_pkg::CFG_DW-1:0]   cfg_wdata
);
	import qvr_pkg::*;

	localparam logic [2:0] ST_SUM   = 3'd0;
	localparam logic [2:0] ST_SQRT  = 3'd1;
	localparam logic [2:0] ST_CHK   = 3'd2;
	localparam logic [2:0] ST_DIVLD = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_K     = 3'd5;
	localparam logic [2:0] ST_IDLE  = 3'd6;

	// Configuration registers.
	logic signed [15:0] raw_q [4];
	logic [13:0]        eps_q;

	// Setup sequencer.
	logic [2:0]         state_q;
	logic [1:0]         idx_q;
	logic [4:0]         cnt_q;
	logic [32:0]        sum_q;
	logic [33:0]        rad_q;
	logic [20:0]        rem_q;
	logic [16:0]        root_q;
	logic [29:0]        num_q;
	logic [17:0]        drem_q;
	logic [29:0]        quo_q;
	logic signed [33:0] k_q;
	logic signed [15:0] cq_q [4];
	logic               busy_q;

	logic signed [15:0] raw_sel;
	logic signed [31:0] raw_sq;
	logic signed [31:0] cq_sq;
	logic [16:0]        raw_mag;
	logic [20:0]        sq_rem;
	logic [20:0]        sq_trial;
	logic [17:0]        dv_rem;
	logic [17:0]        dv_len;

	always_comb begin
		raw_sel  = raw_q[idx_q];
		raw_sq   = 32'(raw_sel) * 32'(raw_sel);
		cq_sq    = 32'(cq_q[idx_q]) * 32'(cq_q[idx_q]);
		raw_mag  = raw_sel[15] ? 17'(-(17'(raw_sel))) : 17'(raw_sel);
		sq_rem   = {rem_q[18:0], rad_q[33:32]};
		sq_trial = {2'b00, root_q, 2'b01};
		dv_rem   = {drem_q[16:0], num_q[29]};
		dv_len   = {1'b0, root_q};
	end

	// Register writes and the setup pass that derives the coefficients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q[0] <= '0;
			raw_q[1] <= '0;
			raw_q[2] <= '0;
			raw_q[3] <= QUAT_W_RESET;
			eps_q    <= EPS_RESET;
			state_q  <= ST_SUM;
			idx_q    <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			busy_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_QUAT_X: raw_q[0] <= cfg_wdata;
				REG_QUAT_Y: raw_q[1] <= cfg_wdata;
				REG_QUAT_Z: raw_q[2] <= cfg_wdata;
				REG_QUAT_W: raw_q[3] <= cfg_wdata;
				REG_EPS:    eps_q    <= cfg_wdata[13:0];
				default: ;
			endcase
			state_q <= ST_SUM;
			idx_q   <= '0;
			sum_q   <= '0;
			busy_q  <= 1'b1;
		end else begin
			unique case (state_q)
				ST_SUM: begin
					sum_q <= sum_q + 33'(unsigned'(raw_sq));
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						rad_q   <= {1'b0, sum_q + 33'(unsigned'(raw_sq))};
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= 5'd16;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					rad_q <= rad_q << 2;
					if (sq_rem >= sq_trial) begin
						rem_q  <= sq_rem - sq_trial;
						root_q <= {root_q[15:0], 1'b1};
					end else begin
						rem_q  <= sq_rem;
						root_q <= {root_q[15:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					idx_q <= '0;
					if (root_q > 17'(eps_q)) begin
						state_q <= ST_DIVLD;
					end else begin
						cq_q[0] <= raw_q[0];
						cq_q[1] <= raw_q[1];
						cq_q[2] <= raw_q[2];
						cq_q[3] <= raw_q[3];
						k_q     <= '0;
						state_q <= ST_K;
					end
				end
				ST_DIVLD: begin
					if (raw_mag[16]) begin
						num_q <= {1'b1, 29'd0} + 30'(root_q[16:1]);
					end else begin
						num_q <= {raw_mag[15:0], 14'd0} + 30'(root_q[16:1]);
					end
					drem_q  <= '0;
					quo_q   <= '0;
					cnt_q   <= 5'd29;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					num_q <= num_q << 1;
					if (dv_rem >= dv_len) begin
						drem_q <= dv_rem - dv_len;
						quo_q  <= {quo_q[28:0], 1'b1};
					end else begin
						drem_q <= dv_rem;
						quo_q  <= {quo_q[28:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						// Last quotient bit lands here; apply the sign.
						if (raw_sel[15]) begin
							cq_q[idx_q] <= -(16'({quo_q[14:0], dv_rem >= dv_len}));
						end else begin
							cq_q[idx_q] <= 16'({quo_q[14:0], dv_rem >= dv_len});
						end
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							k_q     <= '0;
							state_q <= ST_K;
						end else begin
							state_q <= ST_DIVLD;
						end
					end
				end
				ST_K: begin
					// k = s*s - u.u, scalar last.
					if (idx_q == 2'd3) begin
						k_q     <= k_q + 34'(cq_sq);
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q - 34'(cq_sq);
					end
					idx_q <= idx_q + 2'd1;
				end
				ST_IDLE: ;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = busy_q;

	// Rotation pipeline.
	logic               accept;
	logic [4:0]         vld_q;
	logic signed [15:0] v_s1 [3];
	logic signed [31:0] p_s1 [3][3];
	logic signed [33:0] d_s2;
	logic signed [32:0] c_s2 [3];
	logic signed [49:0] kv_s2 [3];
	logic signed [49:0] kv_s3 [3];
	logic signed [49:0] t1_s3 [3];
	logic signed [48:0] t2_s3 [3];
	logic signed [55:0] acc_s4 [3];
	logic signed [27:0] rnd [3];
	logic signed [15:0] res_s5 [3];

	assign accept = start && !busy_q;

	// Valid bits travel with the beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], accept};
		end
	end

	// Stage 1: the nine products u_i * v_j.
	always_ff @(posedge clk) begin
		v_s1[0] <= vec.vec_x;
		v_s1[1] <= vec.vec_y;
		v_s1[2] <= vec.vec_z;
		p_s1[0][0] <= 32'(cq_q[0]) * 32'(vec.vec_x);
		p_s1[0][1] <= 32'(cq_q[0]) * 32'(vec.vec_y);
		p_s1[0][2] <= 32'(cq_q[0]) * 32'(vec.vec_z);
		p_s1[1][0] <= 32'(cq_q[1]) * 32'(vec.vec_x);
		p_s1[1][1] <= 32'(cq_q[1]) * 32'(vec.vec_y);
		p_s1[1][2] <= 32'(cq_q[1]) * 32'(vec.vec_z);
		p_s1[2][0] <= 32'(cq_q[2]) * 32'(vec.vec_x);
		p_s1[2][1] <= 32'(cq_q[2]) * 32'(vec.vec_y);
		p_s1[2][2] <= 32'(cq_q[2]) * 32'(vec.vec_z);
	end

	// Stage 2: dot product, cross product and k*v.
	always_ff @(posedge clk) begin
		d_s2    <= 34'(p_s1[0][0]) + 34'(p_s1[1][1]) + 34'(p_s1[2][2]);
		c_s2[0] <= 33'(p_s1[1][2]) - 33'(p_s1[2][1]);
		c_s2[1] <= 33'(p_s1[2][0]) - 33'(p_s1[0][2]);
		c_s2[2] <= 33'(p_s1[0][1]) - 33'(p_s1[1][0]);
		for (int i = 0; i < 3; i++) begin
			kv_s2[i] <= 50'(k_q) * 50'(v_s1[i]);
		end
	end

	// Stage 3: d*u and s*c.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t1_s3[i] <= 50'(d_s2) * 50'(cq_q[i]);
			t2_s3[i] <= 49'(c_s2[i]) * 49'(cq_q[3]);
			kv_s3[i] <= kv_s2[i];
		end
	end

	// Stage 4: the exact Q.36 sum.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			acc_s4[i] <= (56'(t1_s3[i]) <<< 1) + 56'(kv_s3[i]) + (56'(t2_s3[i]) <<< 1);
		end
	end

	// Stage 5: round half up to Q8.8 and saturate.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = 28'((acc_s4[i] + 56'sd134217728) >>> 28);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (rnd[i] > 28'sd32767) begin
				res_s5[i] <= 16'sh7fff;
			end else if (rnd[i] < -28'sd32768) begin
				res_s5[i] <= 16'sh8000;
			end else begin
				res_s5[i] <= 16'(rnd[i]);
			end
		end
	end

	assign done      = vld_q[4];
	assign rot.rot_x = res_s5[0];
	assign rot.rot_y = res_s5[1];
	assign rot.rot_z = res_s5[2];

endmodule

/* sv/qvr_checker.sv */
module qvr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_we
);
	import qvr_pkg::*;

	// Every accepted beat gives exactly one strobe after the pipeline latency.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("accepted beat produced no result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##PIPE_LATENCY !done)
		else $error("result strobe without an accepted beat");

	// A register write starts the setup pass at once.
	a_busy_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("busy not raised after a register write");

	// Busy only rises because of a register write.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(cfg_we))
		else $error("busy rose without a register write");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.cfg_we (cfg_we)
);
